// File: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator with reference
// counts: field widths, command and status codes, register map, and the
// structs that pass between its modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Field widths on the ports
    localparam int PAGE_W     = 10;
    localparam int LEN_W      = 11;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int REFCNT_W   = 16;
    localparam int PAGE_SPACE = 1 << PAGE_W;

    // Bitmap word layout: 32 pages per word
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_IDX_W = PAGE_W - BIT_W;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_WIN_FIRST = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LAST  = 1'd1;

    localparam logic [PAGE_W-1:0] WIN_FIRST_RST = 10'd0;
    localparam logic [PAGE_W-1:0] WIN_LAST_RST  = 10'd1023;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_INCREF = 2'd1,
        CMD_DECREF = 2'd2
    } bpa_cmd_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPAGE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    // Allocation window from the register block
    typedef struct packed {
        logic [PAGE_W-1:0] first;
        logic [PAGE_W-1:0] last;
    } bpa_window_t;

    // Per-word run search result
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
        logic [LEN_W-1:0] run;
    } bpa_run_t;

endpackage

// File: rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/bpa_run_find.sv
// ----------------------------------------------------------------------------
// bpa_run_find
// Free-run search over one 32-page bitmap word. Carries the run of free
// pages that ended the previous word and reports the lowest bit at which
// the run reaches the requested length.
// ----------------------------------------------------------------------------
module bpa_run_find (
    input  logic [bpa_pkg::WORD_W-1:0] used_word,  // window-masked used bits
    input  logic [bpa_pkg::LEN_W-1:0]  run_in,     // free run entering bit 0
    input  logic [bpa_pkg::LEN_W-1:0]  len,        // requested run length
    output bpa_pkg::bpa_run_t          res
);

    import bpa_pkg::*;

    logic [LEN_W-1:0]  run_arr [WORD_W];
    logic [WORD_W-1:0] hit_vec;

    // Free run ending at each bit: distance to the last used bit at or
    // below it, or the carried run plus the bits so far
    always_comb
    begin
        logic             found;
        logic [BIT_W-1:0] last_idx;
        for (int j = 0; j < WORD_W; j++)
        begin
            found    = 1'b0;
            last_idx = '0;
            for (int k = 0; k < WORD_W; k++)
            begin
                if (k <= j && used_word[k])
                begin
                    found    = 1'b1;
                    last_idx = BIT_W'(k);
                end
            end
            if (found)
            begin
                run_arr[j] = LEN_W'(j) - LEN_W'(last_idx);
            end
            else
            begin
                run_arr[j] = run_in + LEN_W'(j + 1);
            end
            hit_vec[j] = !used_word[j] && (run_arr[j] >= len);
        end
    end

    // Lowest hit wins; outgoing run is zero if the top bit is used
    always_comb
    begin
        res.hit = |hit_vec;
        res.pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                res.pos = BIT_W'(j);
            end
        end
        res.run = used_word[WORD_W-1] ? '0 : run_arr[WORD_W-1];
    end

endmodule

// File: rtl/core/bpa_cfg.sv
// ----------------------------------------------------------------------------
// bpa_cfg
// APB-style register block holding the allocation window bounds.
// ----------------------------------------------------------------------------
module bpa_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output bpa_pkg::bpa_window_t           window
);

    import bpa_pkg::*;

    logic [PAGE_W-1:0]    win_first_reg;
    logic [PAGE_W-1:0]    win_last_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_first_reg <= WIN_FIRST_RST;
            win_last_reg  <= WIN_LAST_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIN_FIRST: win_first_reg <= pwdata[PAGE_W-1:0];
                REG_WIN_LAST:  win_last_reg  <= pwdata[PAGE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_WIN_FIRST: prdata = APB_DATA_W'(win_first_reg);
            REG_WIN_LAST:  prdata = APB_DATA_W'(win_last_reg);
            default:       prdata = '0;
        endcase
    end

    assign window.first = win_first_reg;
    assign window.last  = win_last_reg;

endmodule

// File: rtl/core/bpa_engine.sv
// ----------------------------------------------------------------------------
// bpa_engine
// Request sequencer: holds the used bitmap and the reference counts in two
// RAMs, scans the bitmap a word per cycle for allocation, marks the found
// run by read-modify-write, and updates counts for incref and decref.
// ----------------------------------------------------------------------------
module bpa_engine #(
    parameter int NUM_PAGES   = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bpa_pkg::bpa_window_t         window,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpa_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bpa_pkg::LEN_W-1:0]    s_len,
    input  logic [bpa_pkg::PAGE_W-1:0]   s_page,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpa_pkg::STATUS_W-1:0] m_status,
    output logic [bpa_pkg::PAGE_W-1:0]   m_page,
    output logic [bpa_pkg::REFCNT_W-1:0] m_count,
    output logic                         m_freed
);

    import bpa_pkg::*;

    // Pages above the port's index range are never reachable
    localparam int EFF_PAGES = (NUM_PAGES < PAGE_SPACE) ? NUM_PAGES : PAGE_SPACE;
    localparam int NUM_WORDS = (EFF_PAGES + WORD_W - 1) / WORD_W;
    localparam int CNT_AW    = $clog2(EFF_PAGES);
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic [PAGE_W-1:0]      LAST_PAGE  = PAGE_W'(EFF_PAGES - 1);
    localparam logic [PAGE_W:0]        PAGE_LIMIT = (PAGE_W + 1)'(EFF_PAGES);
    localparam logic [CNT_AW-1:0]      CLR_LAST   = CNT_AW'(EFF_PAGES - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_PAGE,
        S_DONE
    } state_t;

    // Registers
    state_t                state_reg,      state_next;
    logic [CNT_AW-1:0]     clr_cnt_reg,    clr_cnt_next;
    bpa_cmd_t              cmd_reg,        cmd_next;
    logic [LEN_W-1:0]      len_reg,        len_next;
    logic [PAGE_W-1:0]     page_reg,       page_next;
    logic [WORD_IDX_W-1:0] word_reg,       word_next;
    logic [LEN_W-1:0]      run_reg,        run_next;
    logic [PAGE_W-1:0]     start_reg,      start_next;
    logic [PAGE_W-1:0]     end_reg,        end_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PAGE_W-1:0]     res_page_reg,   res_page_next;
    logic [REFCNT_W-1:0]   res_count_reg,  res_count_next;
    logic                  res_freed_reg,  res_freed_next;
    logic                  m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg,   m_status_next;
    logic [PAGE_W-1:0]     m_page_reg,     m_page_next;
    logic [REFCNT_W-1:0]   m_count_reg,    m_count_next;
    logic                  m_freed_reg,    m_freed_next;

    // RAM ports
    logic                   bm_we, bm_re;
    logic [WORD_AW-1:0]     bm_waddr, bm_raddr;
    logic [WORD_W-1:0]      bm_wdata, bm_rdata;
    logic                   cnt_we, cnt_re;
    logic [CNT_AW-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

    // Misc
    logic                  accept;
    logic                  out_free;
    bpa_cmd_t              in_cmd;
    logic [PAGE_W-1:0]     lo_page, hi_page;
    logic [WORD_W-1:0]     win_lo_mask, win_hi_mask, scan_used;
    logic [WORD_W-1:0]     mark_lo_mask, mark_hi_mask;
    logic [LEN_W-1:0]      hit_start;
    logic [PAGE_W-1:0]     base_page;
    logic                  page_used;
    bpa_run_t              rf;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign in_cmd   = bpa_cmd_t'(s_cmd);

    // Effective window, upper bound clamped to the page store
    assign lo_page = window.first;
    assign hi_page = (window.last > LAST_PAGE) ? LAST_PAGE : window.last;

    // Window mask for the word under scan
    assign base_page   = {word_reg, BIT_W'(0)};
    assign win_lo_mask = (word_reg == lo_page[PAGE_W-1:BIT_W]) ?
                         ~((WORD_W'(1) << lo_page[BIT_W-1:0]) - WORD_W'(1)) : '1;
    assign win_hi_mask = (word_reg == hi_page[PAGE_W-1:BIT_W]) ?
                         WORD_W'(((WORD_W + 1)'(2) << hi_page[BIT_W-1:0]) -
                                 (WORD_W + 1)'(1)) : '1;
    assign scan_used   = bm_rdata | ~(win_lo_mask & win_hi_mask);

    // Run-set mask for the word being marked
    assign mark_lo_mask = (word_reg == start_reg[PAGE_W-1:BIT_W]) ?
                          ~((WORD_W'(1) << start_reg[BIT_W-1:0]) - WORD_W'(1)) : '1;
    assign mark_hi_mask = (word_reg == end_reg[PAGE_W-1:BIT_W]) ?
                          WORD_W'(((WORD_W + 1)'(2) << end_reg[BIT_W-1:0]) -
                                  (WORD_W + 1)'(1)) : '1;

    bpa_run_find u_run_find (
        .used_word (scan_used),
        .run_in    (run_reg),
        .len       (len_reg),
        .res       (rf)
    );

    assign hit_start = LEN_W'(base_page) + LEN_W'(rf.pos) + LEN_W'(1) - len_reg;
    assign page_used = bm_rdata[page_reg[BIT_W-1:0]];

    // Used bitmap, 32 pages per word
    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Reference counts, one per page
    bpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (EFF_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Count RAM is read only when a request is taken
    assign cnt_re    = accept;
    assign cnt_raddr = CNT_AW'(s_page);

    // Bitmap read address
    always_comb
    begin
        bm_re    = 1'b0;
        bm_raddr = WORD_AW'(word_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                bm_re    = accept;
                bm_raddr = (in_cmd == CMD_ALLOC) ? WORD_AW'(lo_page[PAGE_W-1:BIT_W]) :
                                                   WORD_AW'(s_page[PAGE_W-1:BIT_W]);
            end
            S_SCAN, S_MARK:
            begin
                bm_re    = 1'b1;
                bm_raddr = WORD_AW'(word_reg + WORD_IDX_W'(1));
            end
            S_MARK_RD:
            begin
                bm_re    = 1'b1;
                bm_raddr = WORD_AW'(start_reg[PAGE_W-1:BIT_W]);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        page_next       = page_reg;
        word_next       = word_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_count_next  = res_count_reg;
        res_freed_next  = res_freed_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_count_next    = m_count_reg;
        m_freed_next    = m_freed_reg;

        bm_we     = 1'b0;
        bm_waddr  = WORD_AW'(word_reg);
        bm_wdata  = '0;
        cnt_we    = 1'b0;
        cnt_waddr = CNT_AW'(page_reg);
        cnt_wdata = '0;

        unique case (state_reg)
            // Zero both stores after reset
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_cnt_reg;
                bm_we     = (32'(clr_cnt_reg) < NUM_WORDS);
                bm_waddr  = WORD_AW'(clr_cnt_reg);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CNT_AW'(1);
                end
            end

            // Take a request; reads for it are issued at this edge
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = in_cmd;
                    len_next        = s_len;
                    page_next       = s_page;
                    res_status_next = STAT_OK;
                    res_page_next   = '0;
                    res_count_next  = '0;
                    res_freed_next  = 1'b0;
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if (s_len == '0 || lo_page > hi_page)
                            begin
                                res_status_next = STAT_NOSPACE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                word_next  = lo_page[PAGE_W-1:BIT_W];
                                run_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_INCREF, CMD_DECREF:
                        begin
                            res_page_next = s_page;
                            if ({1'b0, s_page} >= PAGE_LIMIT)
                            begin
                                res_status_next = STAT_BADPAGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PAGE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // One bitmap word per cycle
            S_SCAN:
            begin
                if (rf.hit)
                begin
                    start_next = hit_start[PAGE_W-1:0];
                    end_next   = base_page | PAGE_W'(rf.pos);
                    state_next = S_MARK_RD;
                end
                else if (word_reg == hi_page[PAGE_W-1:BIT_W])
                begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + WORD_IDX_W'(1);
                    run_next  = rf.run;
                end
            end

            // First word of the run is being read
            S_MARK_RD:
            begin
                word_next  = start_reg[PAGE_W-1:BIT_W];
                state_next = S_MARK;
            end

            // Set the run's bits word by word
            S_MARK:
            begin
                bm_we    = 1'b1;
                bm_waddr = WORD_AW'(word_reg);
                bm_wdata = bm_rdata | (mark_lo_mask & mark_hi_mask);
                if (word_reg == end_reg[PAGE_W-1:BIT_W])
                begin
                    res_status_next = STAT_OK;
                    res_page_next   = start_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + WORD_IDX_W'(1);
                end
            end

            // Incref / decref on the word and count read at accept
            S_PAGE:
            begin
                res_count_next = REFCNT_W'(cnt_rdata);
                if (cmd_reg == CMD_INCREF)
                begin
                    if (!page_used)
                    begin
                        res_status_next = STAT_BADPAGE;
                    end
                    else if (cnt_rdata == CNT_MAX)
                    begin
                        res_status_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = cnt_rdata + COUNT_WIDTH'(1);
                        res_count_next = REFCNT_W'(cnt_rdata + COUNT_WIDTH'(1));
                    end
                end
                else
                begin
                    if (!page_used || cnt_rdata == '0)
                    begin
                        res_status_next = STAT_BADPAGE;
                    end
                    else
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = cnt_rdata - COUNT_WIDTH'(1);
                        res_count_next = REFCNT_W'(cnt_rdata - COUNT_WIDTH'(1));
                        // Last reference dropped: free this page only
                        if (cnt_rdata == COUNT_WIDTH'(1))
                        begin
                            bm_we    = 1'b1;
                            bm_waddr = WORD_AW'(page_reg[PAGE_W-1:BIT_W]);
                            bm_wdata = bm_rdata &
                                       ~(WORD_W'(1) << page_reg[BIT_W-1:0]);
                            res_freed_next = 1'b1;
                        end
                    end
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_count_next  = res_count_reg;
                    m_freed_next  = res_freed_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            cmd_reg        <= CMD_ALLOC;
            len_reg        <= '0;
            page_reg       <= '0;
            word_reg       <= '0;
            run_reg        <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            res_status_reg <= STAT_OK;
            res_page_reg   <= '0;
            res_count_reg  <= '0;
            res_freed_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= STAT_OK;
            m_page_reg     <= '0;
            m_count_reg    <= '0;
            m_freed_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            page_reg       <= page_next;
            word_reg       <= word_next;
            run_reg        <= run_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            res_status_reg <= res_status_next;
            res_page_reg   <= res_page_next;
            res_count_reg  <= res_count_next;
            res_freed_reg  <= res_freed_next;
            m_valid_reg    <= m_valid_next;
            m_status_reg   <= m_status_next;
            m_page_reg     <= m_page_next;
            m_count_reg    <= m_count_next;
            m_freed_reg    <= m_freed_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_page   = m_page_reg;
    assign m_count  = m_count_reg;
    assign m_freed  = m_freed_reg;

endmodule

// File: rtl/core/bitmap_page_allocator_refcount_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_refcount_top
// Page frame allocator: first-fit run allocation over a used bitmap, with a
// saturating reference count per page.
// ----------------------------------------------------------------------------
// Takes one request at a time. After reset the block runs a clearing pass over
// all min(NUM_PAGES, 1024) entries of the count RAM (and the bitmap) with
// s_tready low; APB writes are taken throughout. Increment and decrement
// work on the page's bitmap word and count read at accept. Allocate scans
// the 32-page bitmap words from the window's first word up to the one where
// the run completes (or the window's last word), then marks each word the
// allocated run spans by read-modify-write. The bitmap RAM's single read
// port delivers one word per cycle. A finished result waits in the output
// register while the next request is accepted. Configure the window
// only while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_refcount_top #(
    parameter int NUM_PAGES   = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // run_length[10:0], page_index[20:11]
    input  logic [1:0]                     s_tuser,  // cmd[1:0]
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // start_page[9:0], ref_count[25:10],
                                                     // page_freed[26]
    output logic [1:0]                     m_tuser,  // status[1:0]
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import bpa_pkg::*;

    bpa_window_t         window;
    logic [PAGE_W-1:0]   out_page;
    logic [REFCNT_W-1:0] out_count;
    logic                out_freed;

    bpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .window  (window)
    );

    bpa_engine #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .window   (window),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_len    (s_tdata[LEN_W-1:0]),
        .s_page   (s_tdata[LEN_W+PAGE_W-1:LEN_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .m_page   (out_page),
        .m_count  (out_count),
        .m_freed  (out_freed)
    );

    // Result packing, zero filled to 32 bits
    assign m_tdata = {5'd0, out_freed, out_count, out_page};

endmodule
